// ===== rtl/gfe_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gfe_pkg
// Shared types and constants for the forward elimination block.
// ---------------------------------------------------------------------------
package gfe_pkg;

   localparam int MAX_N     = 16;
   localparam int FRAC_BITS = 16;
   localparam int STRIDE    = MAX_N + 1;
   localparam int DEPTH     = MAX_N * STRIDE;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int ROW_W     = 4;
   localparam int COL_W     = 5;
   localparam int SIZE_W    = 5;
   localparam int DATA_W    = 32;
   localparam int NUM_W     = DATA_W + FRAC_BITS;
   localparam int DCNT_W    = $clog2(NUM_W);

   localparam logic [DATA_W-1:0] FX_ONE = DATA_W'(1) << FRAC_BITS;
   localparam logic [DATA_W-1:0] FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_READ  = 2'd2,
      OP_RSVD  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      WSEL_REQ,
      WSEL_DIV,
      WSEL_ONE,
      WSEL_SUB
   } wsel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PIV_RD,
      ST_PIV_CHK,
      ST_DIV_RD,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_DIV_WR,
      ST_ONE_WR,
      ST_M_RD,
      ST_M_LD,
      ST_P_RD,
      ST_A_RD,
      ST_MUL,
      ST_SCALE,
      ST_SUB,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              singular;
      logic              saturated;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic             mem_rd;
      logic             mem_wr;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      wsel_type         wsel;
      logic             clr_flags;
      logic             set_sing;
      logic             ld_piv;
      logic             ld_m;
      logic             ld_p;
      logic             mul_go;
      logic             scale_go;
      logic             div_go;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic rd_zero;
      logic div_done;
   } sts_type;

endpackage

// ===== rtl/gfe_dpath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gfe_dpath
// Matrix store, shift-subtract divider, multiplier and saturating subtract.
// ---------------------------------------------------------------------------
module gfe_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  gfe_pkg::cmd_type             cmd,
   input  logic [gfe_pkg::DATA_W-1:0]   req_value,
   output gfe_pkg::sts_type             sts,
   output logic [gfe_pkg::DATA_W-1:0]   rd_data,
   output logic                         singular,
   output logic                         saturated
);
   import gfe_pkg::*;

   localparam logic [NUM_W-1:0] QLIM = NUM_W'(64'h8000_0000);
   localparam logic [63:0]      PLIM = 64'h8000_0000;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] addr;
   logic [DATA_W-1:0] wdata;

   logic [DATA_W-1:0] piv_ff, m_ff, p_ff, a_ff, scaled_ff;
   logic [63:0]       prod_ff;

   logic              div_busy_ff;
   logic [DCNT_W-1:0] div_cnt_ff;
   logic [NUM_W-1:0]  num_ff, quo_ff;
   logic [DATA_W-1:0] rem_ff, den_ff;
   logic              neg_ff;
   logic [DATA_W:0]   rem_sh;
   logic              fits;

   logic [DATA_W-1:0] div_res, scale_res, sub_res;
   logic              div_sat, scale_sat, sub_sat;
   logic [63:0]       pmag, psh;
   logic [DATA_W:0]   diff;
   logic [DATA_W-1:0] amag, pvmag;

   logic sing_ff, sat_ff;

   // Row-major address: row * STRIDE + col
   assign addr = ADDR_W'(cmd.row) * ADDR_W'(STRIDE) + ADDR_W'(cmd.col);

   // Select write data
   always_comb begin
      case (cmd.wsel)
         WSEL_REQ: wdata = req_value;
         WSEL_DIV: wdata = div_res;
         WSEL_ONE: wdata = FX_ONE;
         WSEL_SUB: wdata = sub_res;
         default:  wdata = req_value;
      endcase
   end

   // Store with registered read
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[addr] <= wdata;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

   // Latch operands
   always_ff @(posedge clock) begin
      if (cmd.ld_piv) begin
         piv_ff <= rd_data_ff;
      end
      if (cmd.ld_m) begin
         m_ff <= rd_data_ff;
      end
      if (cmd.ld_p) begin
         p_ff <= rd_data_ff;
      end
      if (cmd.mul_go) begin
         a_ff    <= rd_data_ff;
         prod_ff <= $signed(p_ff) * $signed(m_ff);
      end
      if (cmd.scale_go) begin
         scaled_ff <= scale_res;
      end
   end

   // Scale product back to Q format with truncation toward zero
   always_comb begin
      pmag      = prod_ff[63] ? (~prod_ff + 64'd1) : prod_ff;
      psh       = pmag >> FRAC_BITS;
      scale_sat = 1'b0;
      if (prod_ff[63]) begin
         if (psh > PLIM) begin
            scale_res = FX_MIN;
            scale_sat = 1'b1;
         end else begin
            scale_res = ~psh[DATA_W-1:0] + DATA_W'(1);
         end
      end else begin
         if (psh > (PLIM - 64'd1)) begin
            scale_res = FX_MAX;
            scale_sat = 1'b1;
         end else begin
            scale_res = psh[DATA_W-1:0];
         end
      end
   end

   // Saturating subtract
   always_comb begin
      diff    = {a_ff[DATA_W-1], a_ff} - {scaled_ff[DATA_W-1], scaled_ff};
      sub_sat = diff[DATA_W] != diff[DATA_W-1];
      if (sub_sat) begin
         sub_res = diff[DATA_W] ? FX_MIN : FX_MAX;
      end else begin
         sub_res = diff[DATA_W-1:0];
      end
   end

   // Divider operand magnitudes
   assign amag  = rd_data_ff[DATA_W-1] ? (~rd_data_ff + DATA_W'(1)) : rd_data_ff;
   assign pvmag = piv_ff[DATA_W-1] ? (~piv_ff + DATA_W'(1)) : piv_ff;

   // One restoring step per cycle
   assign rem_sh = {rem_ff, num_ff[NUM_W-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (cmd.div_go) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= '0;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
         if (div_cnt_ff == DCNT_W'(NUM_W - 1)) begin
            div_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_go) begin
         num_ff <= {amag, {FRAC_BITS{1'b0}}};
         den_ff <= pvmag;
         neg_ff <= rd_data_ff[DATA_W-1] ^ piv_ff[DATA_W-1];
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (div_busy_ff) begin
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
         rem_ff <= fits ? DATA_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DATA_W-1:0];
      end
   end

   // Signed, saturated quotient
   always_comb begin
      div_sat = 1'b0;
      if (neg_ff) begin
         if (quo_ff > QLIM) begin
            div_res = FX_MIN;
            div_sat = 1'b1;
         end else begin
            div_res = ~quo_ff[DATA_W-1:0] + DATA_W'(1);
         end
      end else begin
         if (quo_ff > (QLIM - NUM_W'(1))) begin
            div_res = FX_MAX;
            div_sat = 1'b1;
         end else begin
            div_res = quo_ff[DATA_W-1:0];
         end
      end
   end

   // Track status flags
   always_ff @(posedge clock) begin
      if (reset) begin
         sing_ff <= 1'b0;
         sat_ff  <= 1'b0;
      end else if (cmd.clr_flags) begin
         sing_ff <= 1'b0;
         sat_ff  <= 1'b0;
      end else begin
         if (cmd.set_sing) begin
            sing_ff <= 1'b1;
         end
         if ((cmd.scale_go && scale_sat)
             || (cmd.mem_wr && cmd.wsel == WSEL_DIV && div_sat)
             || (cmd.mem_wr && cmd.wsel == WSEL_SUB && sub_sat)) begin
            sat_ff <= 1'b1;
         end
      end
   end

   assign singular     = sing_ff;
   assign saturated    = sat_ff;
   assign sts.rd_zero  = rd_data_ff == '0;
   assign sts.div_done = !div_busy_ff;

endmodule

// ===== rtl/gfe_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gfe_ctrl
// Sequencer that walks pivot, row and column loops of the elimination.
// ---------------------------------------------------------------------------
module gfe_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_accept,
   input  gfe_pkg::req_type             req,
   input  logic                         req_inside,
   input  logic [gfe_pkg::SIZE_W-1:0]   n,
   input  gfe_pkg::sts_type             sts,
   input  logic                         rsp_room,
   output gfe_pkg::cmd_type             cmd,
   output logic                         busy,
   output logic                         done_push
);
   import gfe_pkg::*;

   state_type        state_ff, state_in;
   logic [ROW_W-1:0] k_ff, r_ff;
   logic [COL_W-1:0] j_ff;
   logic             k_last, r_last, j_last;

   assign k_last = (SIZE_W'(k_ff) + SIZE_W'(1)) >= n;
   assign r_last = (SIZE_W'(r_ff) + SIZE_W'(1)) >= n;
   assign j_last = j_ff == COL_W'(n);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req.op == OP_START) state_in = ST_PIV_RD;
         end
         ST_PIV_RD:   state_in = ST_PIV_CHK;
         ST_PIV_CHK:  state_in = sts.rd_zero ? ST_DONE : ST_DIV_RD;
         ST_DIV_RD:   state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (sts.div_done) state_in = ST_DIV_WR;
         end
         ST_DIV_WR:   state_in = j_last ? ST_ONE_WR : ST_DIV_RD;
         ST_ONE_WR:   state_in = k_last ? ST_DONE : ST_M_RD;
         ST_M_RD:     state_in = ST_M_LD;
         ST_M_LD:     state_in = ST_P_RD;
         ST_P_RD:     state_in = ST_A_RD;
         ST_A_RD:     state_in = ST_MUL;
         ST_MUL:      state_in = ST_SCALE;
         ST_SCALE:    state_in = ST_SUB;
         ST_SUB: begin
            if (!j_last)      state_in = ST_P_RD;
            else if (!r_last) state_in = ST_M_RD;
            else              state_in = ST_PIV_RD;
         end
         ST_DONE: begin
            if (rsp_room) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      cmd.wsel  = WSEL_REQ;
      done_push = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.row = req.row;
            cmd.col = req.col;
            if (req_accept) begin
               case (req.op)
                  OP_LOAD:  cmd.mem_wr    = req_inside;
                  OP_READ:  cmd.mem_rd    = 1'b1;
                  OP_START: cmd.clr_flags = 1'b1;
                  default:  cmd.mem_rd    = 1'b0;
               endcase
            end
         end
         ST_PIV_RD: begin
            cmd.mem_rd = 1'b1;
            cmd.row    = k_ff;
            cmd.col    = COL_W'(k_ff);
         end
         ST_PIV_CHK: begin
            cmd.ld_piv   = 1'b1;
            cmd.set_sing = sts.rd_zero;
         end
         ST_DIV_RD: begin
            cmd.mem_rd = 1'b1;
            cmd.row    = k_ff;
            cmd.col    = j_ff;
         end
         ST_DIV_GO:   cmd.div_go = 1'b1;
         ST_DIV_WAIT: cmd.div_go = 1'b0;
         ST_DIV_WR: begin
            cmd.mem_wr = 1'b1;
            cmd.wsel   = WSEL_DIV;
            cmd.row    = k_ff;
            cmd.col    = j_ff;
         end
         ST_ONE_WR: begin
            cmd.mem_wr = 1'b1;
            cmd.wsel   = WSEL_ONE;
            cmd.row    = k_ff;
            cmd.col    = COL_W'(k_ff);
         end
         ST_M_RD: begin
            cmd.mem_rd = 1'b1;
            cmd.row    = r_ff;
            cmd.col    = COL_W'(k_ff);
         end
         ST_M_LD:  cmd.ld_m = 1'b1;
         ST_P_RD: begin
            cmd.mem_rd = 1'b1;
            cmd.row    = k_ff;
            cmd.col    = j_ff;
         end
         ST_A_RD: begin
            cmd.ld_p   = 1'b1;
            cmd.mem_rd = 1'b1;
            cmd.row    = r_ff;
            cmd.col    = j_ff;
         end
         ST_MUL:   cmd.mul_go   = 1'b1;
         ST_SCALE: cmd.scale_go = 1'b1;
         ST_SUB: begin
            cmd.mem_wr = 1'b1;
            cmd.wsel   = WSEL_SUB;
            cmd.row    = r_ff;
            cmd.col    = j_ff;
         end
         ST_DONE:  done_push = rsp_room;
         default:  done_push = 1'b0;
      endcase
   end

   // State and loop counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         r_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE:    k_ff <= '0;
            ST_PIV_CHK: j_ff <= COL_W'(k_ff) + COL_W'(1);
            ST_DIV_WR:  j_ff <= j_ff + COL_W'(1);
            ST_ONE_WR:  r_ff <= k_ff + ROW_W'(1);
            ST_M_LD:    j_ff <= COL_W'(k_ff);
            ST_SUB: begin
               j_ff <= j_ff + COL_W'(1);
               if (j_last) begin
                  if (!r_last) r_ff <= r_ff + ROW_W'(1);
                  else         k_ff <= k_ff + ROW_W'(1);
               end
            end
            default:    k_ff <= k_ff;
         endcase
      end
   end

   assign busy = state_ff != ST_IDLE;

endmodule

// ===== rtl/gaussian_forward_elimination.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gaussian_forward_elimination
// Fixed-point forward elimination without pivoting on a local matrix store.
// ---------------------------------------------------------------------------
// Load and read requests are taken one per clock while the block is idle
// and the response queue has room; read data is registered in the store and
// then passes a two-entry response queue. A start request runs the whole
// elimination on the one store port, ending early at a zero pivot: per pivot
// row, a pivot fetch and a pivot write, then per right-hand element a read and
// a write around the 48-step serial divider, then per element of every lower
// row two reads, multiply, rescale and subtract-write, plus a multiplier load
// per row. Requests stall until the start response is queued.
module gaussian_forward_elimination (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  gfe_pkg::req_type             req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output gfe_pkg::rsp_type             rsp_payload,
   input  logic                         csr_write_enable,
   input  logic [gfe_pkg::SIZE_W-1:0]   csr_write_data
);
   import gfe_pkg::*;

   logic [SIZE_W-1:0] size_ff;
   logic [SIZE_W-1:0] n;
   logic              in_range;
   logic              req_accept;
   cmd_type           cmd;
   sts_type           sts;
   logic              busy, done_push;
   logic [DATA_W-1:0] rd_data;
   logic              singular, saturated;

   logic              pend_ff, pend_in;
   logic              pend_inside_ff;
   rsp_type           q_ff [2];
   rsp_type           q_in [2];
   logic [1:0]        cnt_ff, cnt_in;
   logic              pop, push;
   rsp_type           push_item;
   logic [1:0]        slots;
   logic [1:0]        base;

   // Size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(MAX_N);
      end else if (csr_write_enable) begin
         size_ff <= csr_write_data;
      end
   end

   assign n = (size_ff == '0) ? SIZE_W'(1)
            : (size_ff > SIZE_W'(MAX_N)) ? SIZE_W'(MAX_N) : size_ff;
   assign in_range = (SIZE_W'(req_payload.row) < n) && (req_payload.col <= n);

   // Accept while idle and the queue has room for the answer
   assign pop        = rsp_valid && !rsp_stall;
   assign slots      = cnt_ff + {1'b0, pend_ff} - {1'b0, pop};
   assign req_stall  = busy || (slots >= 2'd2);
   assign req_accept = req_valid && !req_stall;

   // Track read in flight through the store
   assign pend_in = req_accept && req_payload.op == OP_READ;
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end
   always_ff @(posedge clock) begin
      pend_inside_ff <= in_range;
   end

   // Response queue
   always_comb begin
      push               = pend_ff || done_push;
      push_item.data     = (pend_ff && pend_inside_ff) ? rd_data : '0;
      push_item.singular = singular;
      push_item.saturated = saturated;
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      base    = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         base    = cnt_ff - 2'd1;
      end
      if (push) begin
         if (base == 2'd0) q_in[0] = push_item;
         else              q_in[1] = push_item;
      end
      cnt_in = base + {1'b0, push};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

   assign rsp_valid   = cnt_ff != '0;
   assign rsp_payload = q_ff[0];

   gfe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req        (req_payload),
      .req_inside (in_range),
      .n          (n),
      .sts        (sts),
      .rsp_room   (cnt_ff < 2'd2 || pop),
      .cmd        (cmd),
      .busy       (busy),
      .done_push  (done_push)
   );

   gfe_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_value (req_payload.value),
      .sts       (sts),
      .rd_data   (rd_data),
      .singular  (singular),
      .saturated (saturated)
   );

endmodule
